@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high.
`define EABC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define EABC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/eabc_pkg.sv @@
// Types and codes shared by the encoder and button classifier.
package eabc_pkg;

  localparam int CfgWidth   = 8;
  localparam int CountWidth = 8;
  localparam int EventWidth = 3;
  localparam int DataWidth  = 8;
  localparam int IndexWidth = 2;

  localparam logic [CfgWidth-1:0] DebounceReset = 8'd13;
  localparam logic [CfgWidth-1:0] LongReset     = 8'd100;
  localparam logic [CfgWidth-1:0] WindowReset   = 8'd40;
  localparam logic [CountWidth-1:0] CountMax    = 8'd255;

  typedef enum logic [IndexWidth-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_WINDOW   = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_HOLD     = 3'd2,
    PH_WINDOW   = 3'd3,
    PH_RELEASE  = 3'd4
  } phase_t;

  typedef enum logic [EventWidth-1:0] {
    EV_NONE   = 3'd0,
    EV_TURN_A = 3'd1,
    EV_TURN_B = 3'd2,
    EV_SINGLE = 3'd3,
    EV_DOUBLE = 3'd4,
    EV_LONG   = 3'd5
  } event_t;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ticks;
    logic [CfgWidth-1:0] long_press_ticks;
    logic [CfgWidth-1:0] double_window_ticks;
  } cfg_t;

  // Bit 0 is encoder_clock, matching the input tdata layout.
  typedef struct packed {
    logic button_level;
    logic encoder_direction;
    logic encoder_clock;
  } pins_t;

endpackage

@@ hdl/eabc_cfg.sv @@
// Configuration register file for the classifier thresholds.
module eabc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [eabc_pkg::IndexWidth-1:0] cfg_index,
  input  logic [eabc_pkg::CfgWidth-1:0] cfg_data,
  output eabc_pkg::cfg_t                cfg
);
  import eabc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks      <= DebounceReset;
      cfg.long_press_ticks    <= LongReset;
      cfg.double_window_ticks <= WindowReset;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_DEBOUNCE: cfg.debounce_ticks      <= cfg_data;
        REG_LONG:     cfg.long_press_ticks    <= cfg_data;
        REG_WINDOW:   cfg.double_window_ticks <= cfg_data;
        default:      ;
      endcase
    end
  end

endmodule

@@ hdl/eabc_fsm.sv @@
// Encoder turn latch and button phase state machine, one step per enable.
module eabc_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  eabc_pkg::pins_t     pins,
  input  eabc_pkg::cfg_t      cfg,
  output eabc_pkg::event_t    ev
);
  import eabc_pkg::*;

  phase_t                phase, phase_next;
  logic [CountWidth-1:0] tick_count, tick_count_next;
  logic                  turn_latch, turn_latch_next;

  logic                  pressed;
  logic                  latch_eff;
  logic                  turn;
  logic [CountWidth-1:0] count_inc;

  assign pressed   = ~pins.button_level;
  assign latch_eff = pins.encoder_clock ? 1'b0 : turn_latch;
  assign turn      = ~pins.encoder_clock & ~turn_latch;
  assign count_inc = (tick_count == CountMax) ? tick_count : tick_count + 1'b1;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    turn_latch_next = turn_latch;
    unique case (phase)
      PH_IDLE: begin
        if (turn) begin
          turn_latch_next = 1'b1;
        end else begin
          turn_latch_next = latch_eff;
          if (pressed && !latch_eff) begin
            phase_next      = PH_DEBOUNCE;
            tick_count_next = '0;
          end
        end
      end
      PH_DEBOUNCE: begin
        tick_count_next = count_inc;
        if (count_inc >= cfg.debounce_ticks) begin
          tick_count_next = '0;
          phase_next      = pressed ? PH_HOLD : PH_IDLE;
        end
      end
      PH_HOLD: begin
        if (!pressed) begin
          phase_next      = PH_WINDOW;
          tick_count_next = '0;
        end else begin
          tick_count_next = count_inc;
          if (count_inc >= cfg.long_press_ticks) begin
            phase_next      = PH_RELEASE;
            tick_count_next = '0;
          end
        end
      end
      PH_WINDOW: begin
        tick_count_next = count_inc;
        if (pressed) begin
          phase_next      = PH_RELEASE;
          tick_count_next = '0;
        end else if (count_inc >= cfg.double_window_ticks) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end
      end
      PH_RELEASE: begin
        if (!pressed) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
  end

  always_comb begin
    ev = EV_NONE;
    unique case (phase)
      PH_IDLE: begin
        if (turn) begin
          ev = pins.encoder_direction ? EV_TURN_B : EV_TURN_A;
        end
      end
      PH_HOLD: begin
        if (pressed && count_inc >= cfg.long_press_ticks) begin
          ev = EV_LONG;
        end
      end
      PH_WINDOW: begin
        if (pressed) begin
          ev = EV_DOUBLE;
        end else if (count_inc >= cfg.double_window_ticks) begin
          ev = EV_SINGLE;
        end
      end
      default: ev = EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      turn_latch <= 1'b0;
    end else if (en) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      turn_latch <= turn_latch_next;
    end
  end

endmodule

@@ hdl/encoder_and_button_click_classifier_core.sv @@
// Top level of the encoder and button click classifier.
// One pin sample per transaction goes in and exactly one event code comes out
// for it, in order. A sample is taken into an input register and classified by the
// state machine as it moves into the output register, where its event is presented.
// One sample per cycle is sustained while the output side accepts; while a result
// waits, one more sample can be held in the input register.
// Configuration writes take effect on the next sample classified.
module encoder_and_button_click_classifier_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [0] encoder_clock, [1] encoder_direction, [2] button_level, [7:3] zero
  input  logic [eabc_pkg::DataWidth-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [2:0] event_res, [7:3] zero
  output logic [eabc_pkg::DataWidth-1:0]   m_tdata,
  input  logic                             cfg_we,
  input  logic [eabc_pkg::IndexWidth-1:0]  cfg_index,
  input  logic [eabc_pkg::CfgWidth-1:0]    cfg_data
);
  import eabc_pkg::*;

  cfg_t   cfg;
  pins_t  in_pins;
  logic   in_valid;
  logic   advance;
  event_t ev;

  assign advance  = ~m_tvalid | m_tready;
  assign s_tready = ~in_valid | advance;

  eabc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  eabc_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .en   (in_valid & advance),
    .pins (in_pins),
    .cfg  (cfg),
    .ev   (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_pins <= pins_t'(s_tdata[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_tdata <= {{(DataWidth-EventWidth){1'b0}}, ev};
    end
  end

endmodule

@@ hdl/eabc_checker.sv @@
// Port-level checker for the classifier core, bound to the top level.
`include "assert_macros.svh"

module eabc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [eabc_pkg::DataWidth-1:0]  m_tdata
);
  import eabc_pkg::*;

  `EABC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid after reset")
  `EABC_ASSERT(a_ready_when_empty, clk, rst, !m_tvalid |-> s_tready, "input stalled with empty output")
  `EABC_ASSERT(a_event_code, clk, rst, m_tvalid |-> m_tdata[EventWidth-1:0] <= EV_LONG, "bad event")
  `EABC_ASSERT(a_hold_stalled, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

endmodule

bind encoder_and_button_click_classifier_core eabc_checker u_eabc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
